// File: rtl/core/mmcs_pkg.sv
// Shared widths, request and status codes, control structs and bit-search
// helpers for the circular mismatch map. No dependencies.
package mmcs_pkg;

    localparam int REQ_W           = 2;
    localparam int POS_W           = 12;
    localparam int LEN_W           = 13;
    localparam int CHR_W           = 8;
    localparam int ST_W            = 2;
    localparam int WORD_BITS       = 64;
    localparam int WORD_LOG        = 6;
    localparam int POS_SPAN        = 4096;
    localparam int MAX_COLUMNS_DEF = 4096;

    localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FWD    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_BWD    = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_NONE  = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture the accepted item
        logic rd_word;     // read the word holding the item's column
        logic res_range;   // result: column outside active length
        logic res_rmw;     // result of update/query, write back on update
        logic srch_start;  // first word read of a search
        logic srch_run;    // keep reading and evaluating words
        logic res_search;  // result of the search
        logic load_out;    // move the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_range;
        logic is_search;
        logic ev_valid;
        logic ev_hit;
        logic ev_last;
    } t_dp_status;

    // Lowest set bit: {found, index}
    function automatic logic [WORD_LOG:0] find_low(input logic [WORD_BITS-1:0] w);
        logic [WORD_LOG:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                r = {1'b1, WORD_LOG'(i)};
            end
        end
        return r;
    endfunction

    // Highest set bit: {found, index}
    function automatic logic [WORD_LOG:0] find_high(input logic [WORD_BITS-1:0] w);
        logic [WORD_LOG:0] r;
        r = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (w[i]) begin
                r = {1'b1, WORD_LOG'(i)};
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/core/mmcs_intf.sv
// Valid/ready channel interfaces for request items and result items.
// Depends on mmcs_pkg for field widths.
interface mmcs_req_if;
    import mmcs_pkg::*;
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [POS_W-1:0] position;
    logic [CHR_W-1:0] consensus_char;
    logic [CHR_W-1:0] reference_char;

    modport source (output valid, req_type, position, consensus_char, reference_char,
                    input ready);
    modport sink   (input valid, req_type, position, consensus_char, reference_char,
                    output ready);
endinterface

interface mmcs_rsp_if;
    import mmcs_pkg::*;
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic             mismatch_bit;
    logic [POS_W-1:0] found_position;

    modport source (output valid, status, mismatch_bit, found_position, input ready);
    modport sink   (input valid, status, mismatch_bit, found_position, output ready);
endinterface

// File: rtl/core/mmcs_ctrl.sv
// Sequencing state machine of the circular mismatch map.
// Depends on mmcs_pkg (command and status structs).
module mmcs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  mmcs_pkg::t_dp_status i_st,
    output mmcs_pkg::t_dp_cmd   o_cmd
);
    import mmcs_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_RMW    = 3'd2;
    localparam logic [2:0] ST_SEARCH = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_vld, n_out_vld;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!i_st.in_range) begin
                    o_cmd.res_range = 1'b1;
                    n_state         = ST_FINISH;
                end else if (i_st.is_search) begin
                    o_cmd.srch_start = 1'b1;
                    n_state          = ST_SEARCH;
                end else begin
                    o_cmd.rd_word = 1'b1;
                    n_state       = ST_RMW;
                end
            end
            ST_RMW: begin
                o_cmd.res_rmw = 1'b1;
                n_state       = ST_FINISH;
            end
            ST_SEARCH: begin
                o_cmd.srch_run = 1'b1;
                if (i_st.ev_valid && (i_st.ev_hit || i_st.ev_last)) begin
                    o_cmd.res_search = 1'b1;
                    n_state          = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold the result until the output register is free
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.load_out) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_EXEC))
        else $error("accepted item did not move to execute");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.res_range, o_cmd.res_rmw, o_cmd.res_search}))
        else $error("more than one result source in a cycle");

    a_search_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> i_st.ev_valid)
        else $error("search cycle without a word to evaluate");

endmodule

// File: rtl/core/mmcs_dpath.sv
// Datapath of the circular mismatch map: word memory with valid flags,
// search read pipeline, bit search, result and output registers. Uses mmcs_pkg.
module mmcs_dpath #(
    parameter int MAX_COLUMNS = mmcs_pkg::MAX_COLUMNS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mmcs_pkg::LEN_W-1:0]    i_cfg_wdata,
    input  logic [mmcs_pkg::REQ_W-1:0]    i_req_type,
    input  logic [mmcs_pkg::POS_W-1:0]    i_position,
    input  logic [mmcs_pkg::CHR_W-1:0]    i_consensus_char,
    input  logic [mmcs_pkg::CHR_W-1:0]    i_reference_char,
    input  mmcs_pkg::t_dp_cmd             i_cmd,
    output mmcs_pkg::t_dp_status          o_st,
    output logic [mmcs_pkg::ST_W-1:0]     o_status,
    output logic                          o_mismatch_bit,
    output logic [mmcs_pkg::POS_W-1:0]    o_found_position
);
    import mmcs_pkg::*;

    localparam int COLS = (MAX_COLUMNS < POS_SPAN) ? MAX_COLUMNS : POS_SPAN;
    localparam int NW   = (COLS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW   = (NW > 1) ? $clog2(NW) : 1;
    localparam int VW   = $clog2(NW + 2);

    // captured item
    logic [REQ_W-1:0] r_type;
    logic [POS_W-1:0] r_pos;
    logic [CHR_W-1:0] r_cons, r_ref;

    // length and map
    logic [LEN_W-1:0]     r_len;
    logic [AW-1:0]        r_lastw;
    logic [NW-1:0]        r_wvalid;
    logic [WORD_BITS-1:0] mem [NW];
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_rvld;

    // search pipeline
    logic [VW-1:0] r_visit;
    logic [AW-1:0] r_next;
    logic          r_ev_valid;
    logic [AW-1:0] r_ev_word;
    logic          r_ev_first, r_ev_last;

    // result and output registers
    logic [ST_W-1:0]  r_res_status, r_out_status;
    logic             r_res_bit, r_out_bit;
    logic [POS_W-1:0] r_res_found, r_out_found;

    logic [LEN_W-1:0]     w_len_eff;
    logic [AW-1:0]        w_sw;
    logic [WORD_LOG-1:0]  w_sb;
    logic                 w_fwd;
    logic [WORD_BITS-1:0] w_word, w_ge, w_gt, w_mask, w_new;
    logic [VW-1:0]        w_last_vis, w_iss_vis;
    logic                 w_issue, w_rd_en, w_wr_en, w_ub;
    logic [AW-1:0]        w_iss_addr, w_rd_addr, w_step;
    logic [WORD_LOG:0]    w_ff;
    logic [POS_W-1:0]     w_hit_pos;

    assign w_len_eff  = (32'(i_cfg_wdata) > COLS) ? LEN_W'(COLS) : i_cfg_wdata;
    assign w_sw       = AW'(r_pos >> WORD_LOG);
    assign w_sb       = r_pos[WORD_LOG-1:0];
    assign w_fwd      = (r_type == REQ_FWD);
    assign w_word     = r_rvld ? r_rdata : '0;
    assign w_last_vis = VW'(r_lastw) + VW'(1);

    // issue one word read a cycle until the start word has been seen twice
    assign w_issue    = i_cmd.srch_start | (i_cmd.srch_run & (r_visit <= w_last_vis));
    assign w_iss_addr = i_cmd.srch_start ? w_sw : r_next;
    assign w_iss_vis  = i_cmd.srch_start ? '0 : r_visit;
    assign w_rd_en    = i_cmd.rd_word | w_issue;
    assign w_rd_addr  = i_cmd.rd_word ? w_sw : w_iss_addr;

    always_comb begin
        if (w_fwd) begin
            w_step = (w_iss_addr == r_lastw) ? '0 : AW'(w_iss_addr + AW'(1));
        end else begin
            w_step = (w_iss_addr == '0) ? r_lastw : AW'(w_iss_addr - AW'(1));
        end
    end

    // masks around the start bit: first visit looks past it, last visit up to it
    assign w_ge = {WORD_BITS{1'b1}} << w_sb;
    assign w_gt = w_ge << 1;

    always_comb begin
        w_mask = {WORD_BITS{1'b1}};
        if (r_ev_first) begin
            w_mask = w_fwd ? w_gt : ~w_ge;
        end else if (r_ev_last) begin
            w_mask = w_fwd ? ~w_gt : w_ge;
        end
    end

    assign w_ff      = w_fwd ? find_low(w_word & w_mask) : find_high(w_word & w_mask);
    assign w_hit_pos = POS_W'({r_ev_word, w_ff[WORD_LOG-1:0]});

    assign w_ub    = (r_cons != r_ref);
    assign w_new   = (w_word & ~(WORD_BITS'(1) << w_sb)) | (WORD_BITS'(w_ub) << w_sb);
    assign w_wr_en = i_cmd.res_rmw & (r_type == REQ_UPDATE);

    assign o_st.in_range  = ({1'b0, r_pos} < r_len);
    assign o_st.is_search = (r_type == REQ_FWD) || (r_type == REQ_BWD);
    assign o_st.ev_valid  = r_ev_valid;
    assign o_st.ev_hit    = w_ff[WORD_LOG];
    assign o_st.ev_last   = r_ev_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type <= i_req_type;
            r_pos  <= i_position;
            r_cons <= i_consensus_char;
            r_ref  <= i_reference_char;
        end
    end

    // map memory: one read and one write port
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rdata <= mem[w_rd_addr];
            r_rvld  <= r_wvalid[w_rd_addr];
        end
        if (w_wr_en) begin
            mem[w_sw] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= LEN_W'(COLS);
            r_lastw  <= AW'((COLS - 1) >> WORD_LOG);
            r_wvalid <= '0;
        end else if (i_cfg_we) begin
            r_len    <= w_len_eff;
            r_lastw  <= AW'(LEN_W'(w_len_eff - LEN_W'(1)) >> WORD_LOG);
            r_wvalid <= '0;
        end else if (w_wr_en) begin
            r_wvalid[w_sw] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_valid <= 1'b0;
        end else begin
            r_ev_valid <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_visit    <= VW'(w_iss_vis + VW'(1));
            r_next     <= w_step;
            r_ev_word  <= w_iss_addr;
            r_ev_first <= (w_iss_vis == '0);
            r_ev_last  <= (w_iss_vis == w_last_vis);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_range) begin
            r_res_status <= ST_RANGE;
            r_res_bit    <= 1'b0;
            r_res_found  <= '0;
        end else if (i_cmd.res_rmw) begin
            r_res_status <= ST_OK;
            r_res_bit    <= (r_type == REQ_UPDATE) ? w_ub : w_word[w_sb];
            r_res_found  <= '0;
        end else if (i_cmd.res_search) begin
            r_res_status <= w_ff[WORD_LOG] ? ST_OK : ST_NONE;
            r_res_bit    <= 1'b0;
            r_res_found  <= w_ff[WORD_LOG] ? w_hit_pos : '0;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_bit    <= r_res_bit;
            r_out_found  <= r_res_found;
        end
    end

    assign o_status         = r_out_status;
    assign o_mismatch_bit   = r_out_bit;
    assign o_found_position = r_out_found;

    a_rmw_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> $past(w_rd_en))
        else $error("map write without a preceding word read");

    a_hit_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ev_valid && o_st.ev_hit) |-> (LEN_W'(w_hit_pos) < r_len))
        else $error("search hit beyond active length");

    a_last_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ev_valid && r_ev_last) |-> (r_ev_word == w_sw))
        else $error("final search visit is not the start word");

endmodule

// File: rtl/core/mismatch_map_circular_search.sv
// Top level of the circular mismatch map: controller, datapath and channel wiring.
// Depends on mmcs_pkg, mmcs_intf, mmcs_ctrl and mmcs_dpath.

// The block holds one mismatch bit per alignment column, stored as 64-bit
// words in an on-chip memory with a valid flag per word; writing the length
// register drops every valid flag, so the map reads as all zeros at once with
// no clearing pass. One request item is worked at a time and gives exactly one
// result item. An update or a query runs through capture, word read,
// write-back/result and output load before the next item is accepted. A search
// reads one word per cycle through the single memory read port, starting at
// the word of the start column, wrapping at the last word in use and ending at
// the start word again, and ends early at the first hit. A position at or
// beyond the active length returns at once with the range status. Results sit
// in an output register, so a finished item can wait for the consumer while the
// block is already back at idle; the block accepts a new item only once the
// previous result has entered that register. Write the length register only
// while the block is idle.
module mismatch_map_circular_search #(
    parameter int MAX_COLUMNS = mmcs_pkg::MAX_COLUMNS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    mmcs_req_if.sink                   i_req,
    mmcs_rsp_if.source                 o_rsp,
    input  logic                       i_cfg_we,
    input  logic [mmcs_pkg::LEN_W-1:0] i_cfg_wdata
);
    import mmcs_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_st;

    // sequencing: handshakes and the step order of each item
    mmcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_st        (w_st),
        .o_cmd       (w_cmd)
    );

    // storage, word search and result registers
    mmcs_dpath #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_req_type       (i_req.req_type),
        .i_position       (i_req.position),
        .i_consensus_char (i_req.consensus_char),
        .i_reference_char (i_req.reference_char),
        .i_cmd            (w_cmd),
        .o_st             (w_st),
        .o_status         (o_rsp.status),
        .o_mismatch_bit   (o_rsp.mismatch_bit),
        .o_found_position (o_rsp.found_position)
    );

endmodule

// File: tb/mmcs_map_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the circular mismatch map: watches both channels and the length port,
// predicts each result from its own copy of the map, and compares.
// Depends on mmcs_pkg, mmcs_intf.
module mmcs_map_checker #(
    parameter int MAX_COLUMNS = mmcs_pkg::MAX_COLUMNS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    mmcs_req_if                        i_req,
    mmcs_rsp_if                        i_rsp,
    input  logic                       i_cfg_we,
    input  logic [mmcs_pkg::LEN_W-1:0] i_cfg_wdata,
    output int                         o_err_count,
    output int                         o_pending
);
    import mmcs_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic             mm_bit;
        logic [POS_W-1:0] found;
    } t_col_result;

    logic        column_map [0:MAX_COLUMNS-1];
    logic [LEN_W-1:0] length_reg;
    t_col_result expected_q [$];
    int          errs = 0;

    // Work out one result; an update also writes the column.
    function automatic t_col_result predict_result(input logic [REQ_W-1:0] rt,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [CHR_W-1:0] cons,
                                                   input logic [CHR_W-1:0] refc);
        t_col_result r;
        int          n;
        int          p;
        logic        hit;
        r   = '0;
        n   = (int'(length_reg) > MAX_COLUMNS) ? MAX_COLUMNS : int'(length_reg);
        hit = 1'b0;
        if (int'(pos) >= n) begin
            r.status = ST_RANGE;
        end else begin
            case (rt)
                REQ_UPDATE: begin
                    column_map[pos] = (cons != refc);
                    r.mm_bit        = (cons != refc);
                end
                REQ_QUERY: begin
                    r.mm_bit = column_map[pos];
                end
                REQ_FWD, REQ_BWD: begin
                    // start column comes up last, after a full lap
                    p = int'(pos);
                    for (int k = 0; k < n && !hit; k++) begin
                        if (rt == REQ_FWD) p = (p + 1 >= n) ? 0 : p + 1;
                        else p = (p == 0) ? n - 1 : p - 1;
                        hit = column_map[p];
                    end
                    if (hit) r.found = POS_W'(p);
                    else r.status = ST_NONE;
                end
                default: begin
                    r = '0;
                end
            endcase
        end
        return r;
    endfunction

    // Four-state compare so an unknown output never slips through.
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errs++;
        end
    endtask

    always @(posedge i_clk) begin
        t_col_result want;
        if (!i_rst_n) begin
            foreach (column_map[k]) column_map[k] = 1'b0;
            length_reg = LEN_W'(POS_SPAN);
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                length_reg = i_cfg_wdata;
                foreach (column_map[k]) column_map[k] = 1'b0;
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_q.size() == 0) begin
                    $display({"%0t: unexpected result, expected none, ",
                              "actual status %0d bit %0d pos %0d"},
                             $time, i_rsp.status, i_rsp.mismatch_bit, i_rsp.found_position);
                    errs++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("status", want.status, i_rsp.status);
                    check_field("mismatch_bit", want.mm_bit, i_rsp.mismatch_bit);
                    check_field("found_position", want.found, i_rsp.found_position);
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_q.push_back(predict_result(i_req.req_type, i_req.position,
                                                    i_req.consensus_char, i_req.reference_char));
            end
        end
        o_pending   <= expected_q.size();
        o_err_count <= errs;
    end

endmodule

// File: tb/mismatch_map_circular_search_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the circular mismatch map: directed corner items, then random
// traffic under three idling profiles and several lengths. Depends on mmcs_pkg, mmcs_intf, checker.
module mismatch_map_circular_search_tb;
    import mmcs_pkg::*;

    // Worst item is a full-length search plus random stalls on both sides;
    // a few hundred items stay far below this.
    localparam int LIMIT = 400000;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [LEN_W-1:0] i_cfg_wdata;
    logic             rsp_ready_q = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;
    int err_count;
    int pending;
    int cur_len;       // effective length in force, used to aim positions

    mmcs_req_if req_ch ();
    mmcs_rsp_if rsp_ch ();

    assign rsp_ch.ready = rsp_ready_q;

    mismatch_map_circular_search u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    mmcs_map_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    // Consumer side: drop ready at random per the current idling profile.
    always @(posedge i_clk) begin
        rsp_ready_q <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("mismatch_map_circular_search_tb: done, errors");
            $finish;
        end
    end

    // Present one item and hold it until accepted. Valid is not lowered on exit, so
    // back-to-back items keep it high; idle gaps and drains lower it.
    task automatic send_item(input logic [REQ_W-1:0] rt, input int pos,
                             input logic [CHR_W-1:0] cons, input logic [CHR_W-1:0] refc);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= rt;
        req_ch.position       <= POS_W'(pos);
        req_ch.consensus_char <= cons;
        req_ch.reference_char <= refc;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // Hold off the sender until every outstanding result is back, then settle.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the length register with the block idle; this clears the map.
    task automatic write_length(input int len);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= LEN_W'(len);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_len = (len > POS_SPAN) ? POS_SPAN : len;
    endtask

    // Mostly small lengths so searches wrap often, plus the extremes and out-of-range values.
    function automatic int pick_length();
        case ($urandom_range(13))
            0:       return 1;
            1:       return 2;
            2:       return 63;
            3:       return 64;
            4:       return 65;
            5:       return 128;
            6:       return 0;
            7:       return 8191;
            8:       return 4096;
            9:       return 4095;
            10:      return $urandom_range(4096, 1);
            default: return $urandom_range(300, 1);
        endcase
    endfunction

    task automatic random_item();
        int               sel;
        int               pos;
        logic [REQ_W-1:0] rt;
        logic [CHR_W-1:0] cons;
        logic [CHR_W-1:0] refc;
        sel = $urandom_range(99);
        // aim mostly inside the active length, with the edges and some strays
        if (cur_len == 0 || sel < 8) pos = $urandom_range(4095);
        else if (sel < 16) pos = cur_len - 1;
        else if (sel < 22) pos = 0;
        else pos = $urandom_range(cur_len - 1);
        sel = $urandom_range(99);
        if (sel < 40) rt = REQ_UPDATE;
        else if (sel < 60) rt = REQ_QUERY;
        else if (sel < 80) rt = REQ_FWD;
        else rt = REQ_BWD;
        cons = CHR_W'($urandom);
        refc = $urandom_range(1) ? cons : CHR_W'($urandom);
        send_item(rt, pos, cons, refc);
    endtask

    initial begin
        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_wdata           <= '0;
        req_ch.valid          <= 1'b0;
        req_ch.req_type       <= REQ_UPDATE;
        req_ch.position       <= '0;
        req_ch.consensus_char <= '0;
        req_ch.reference_char <= '0;
        cur_len = POS_SPAN;
        send_idle_pct = 6;
        recv_idle_pct = 64;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty map at full length: both search directions find nothing.
        send_item(REQ_FWD, 0, 8'h00, 8'h00);
        send_item(REQ_BWD, 4095, 8'h00, 8'h00);
        // Mark both end columns and read them back.
        send_item(REQ_UPDATE, 0, 8'h00, 8'hFF);
        send_item(REQ_UPDATE, 4095, 8'hFF, 8'h00);
        send_item(REQ_QUERY, 0, 8'h00, 8'h00);
        send_item(REQ_QUERY, 4095, 8'h00, 8'h00);
        send_item(REQ_QUERY, 1, 8'h00, 8'h00);
        // Wrap around the end in each direction.
        send_item(REQ_FWD, 4095, 8'h00, 8'h00);
        send_item(REQ_BWD, 0, 8'h00, 8'h00);
        send_item(REQ_FWD, 0, 8'h00, 8'h00);
        // Clear column 0; a search from the only set column finds it last.
        send_item(REQ_UPDATE, 0, 8'hAA, 8'hAA);
        send_item(REQ_FWD, 4095, 8'h00, 8'h00);
        send_item(REQ_UPDATE, 2048, 8'h55, 8'hAA);
        send_item(REQ_BWD, 2049, 8'h00, 8'h00);
        send_item(REQ_FWD, 2048, 8'h00, 8'h00);

        // Length of one: only column 0 exists, a search looks at its start only.
        write_length(1);
        send_item(REQ_UPDATE, 1, 8'h01, 8'h02);
        send_item(REQ_FWD, 0, 8'h00, 8'h00);
        send_item(REQ_UPDATE, 0, 8'h01, 8'h02);
        send_item(REQ_BWD, 0, 8'h00, 8'h00);
        send_item(REQ_QUERY, 4095, 8'h00, 8'h00);

        // Length zero: every request is out of range.
        write_length(0);
        send_item(REQ_QUERY, 0, 8'h00, 8'h00);
        send_item(REQ_FWD, 0, 8'h00, 8'h00);

        // Oversized length saturates at the full map, freshly cleared.
        write_length(8191);
        send_item(REQ_QUERY, 4095, 8'h00, 8'h00);
        send_item(REQ_UPDATE, 4095, 8'h12, 8'h34);
        send_item(REQ_BWD, 0, 8'h00, 8'h00);

        // Random traffic: sender light / receiver heavy, then swapped, then no idling.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 64 : 0;
            recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 6 : 0;
            for (int n = 0; n < 135; n++) begin
                if (n % 45 == 0) write_length(pick_length());
                else if ($urandom_range(99) < 3) drain_results();
                random_item();
            end
        end

        // Let the last results out, then watch for strays.
        drain_results();
        repeat (80) @(posedge i_clk);
        if (err_count == 0 && pending == 0) begin
            $display("mismatch_map_circular_search_tb: done, clean");
        end else begin
            $display("mismatch_map_circular_search_tb: done, errors");
        end
        $finish;
    end

endmodule
